// ===== design/fdm_pkg.sv =====
// Package for the floored divide/modulo pipeline.
// Holds the stage record types and the one-bit restoring divide step.
// Used by floored_divide_modulo; depends on nothing else.
package fdm_pkg;

   localparam int FDM_W     = 64;
   localparam int FDM_STEPS = FDM_W;

   typedef struct packed {
      logic [FDM_W-1:0] ub;
      logic [FDM_W-1:0] bm;
      logic [FDM_W-1:0] draw;
      logic             a_neg;
      logic             b_neg;
      logic             mode;
      logic             zero;
   } fdm_pre_type;

   typedef struct packed {
      logic [FDM_W-1:0] rem;
      logic [FDM_W-1:0] num;
      logic [FDM_W-1:0] bm;
      logic [FDM_W-1:0] ubm1;
      logic             a_neg;
      logic             b_neg;
      logic             d_neg;
      logic             mode;
      logic             zero;
   } fdm_div_type;

   typedef struct packed {
      logic [FDM_W-1:0] q;
      logic [FDM_W-1:0] r;
      logic [FDM_W-1:0] ubm1;
      logic             a_neg;
      logic             mode;
      logic             zero;
   } fdm_post_type;

   // shift in one dividend bit, trial-subtract the divisor, shift in a quotient bit
   function automatic fdm_div_type fdm_step(input fdm_div_type s);
      fdm_div_type  o;
      logic [FDM_W:0] part;
      logic [FDM_W:0] diff;
      o    = s;
      part = {s.rem, s.num[FDM_W-1]};
      diff = part - {1'b0, s.bm};
      if (!diff[FDM_W]) begin
         o.rem = diff[FDM_W-1:0];
         o.num = {s.num[FDM_W-2:0], 1'b1};
      end else begin
         o.rem = part[FDM_W-1:0];
         o.num = {s.num[FDM_W-2:0], 1'b0};
      end
      return o;
   endfunction

   function automatic logic [FDM_W-1:0] fdm_sext32(input logic [FDM_W-1:0] x);
      return {{(FDM_W-32){x[31]}}, x[31:0]};
   endfunction

endpackage

// ===== design/floored_divide_modulo.sv =====
// Floored divide/modulo unit: signed 64-bit or 32-bit quotient and remainder.
// Top level; a prepare stage, a magnitude stage, 64 restoring divide stages and two fix-up stages.
// Depends on fdm_pkg.
//
// Usage:
//   Requests enter on req_*: req_tdata carries dividend and divisor, req_tuser
//   selects 32-bit (0) or 64-bit (1) operation. Results leave on rsp_*:
//   rsp_tdata carries quotient and remainder, rsp_tuser flags a zero divisor,
//   in which case quotient and remainder are zero.
//   A request accepted on req_* passes one prepare stage, one magnitude stage,
//   64 one-bit divide stages, one sign stage and the output register before
//   its result shows on rsp_*.
//   Throughput: one request per cycle while rsp_* is not stalled; every divide
//   stage is its own register stage with a valid bit, so 68 requests can be in flight.
//   Reset (synchronous, active high) clears all valid bits; in-flight requests
//   are dropped and nothing appears on rsp_* until new requests come through.
//   When the receiver holds rsp_tready low with a result waiting, the whole
//   pipeline holds; the prepare stage still takes one more request if it is
//   empty. Nothing is lost or repeated across a stall.
module floored_divide_modulo (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,  // dividend [63:0], divisor [127:64]
   input  logic         req_tuser,  // mode [0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,  // quotient [63:0], remainder [127:64]
   output logic         rsp_tuser   // divide_by_zero [0]
);
   import fdm_pkg::*;

   logic                 adv;
   logic                 s1_v_ff;
   fdm_pre_type          s1_ff;
   fdm_pre_type          s1_in;
   logic                 div_v_ff [0:FDM_STEPS];
   fdm_div_type          div_ff   [0:FDM_STEPS];
   fdm_div_type          div0_in;
   logic                 pa_v_ff;
   fdm_post_type         pa_ff;
   fdm_post_type         pa_in;
   logic                 out_v_ff;
   logic [2*FDM_W-1:0]   out_data_ff;
   logic [2*FDM_W-1:0]   out_data_in;
   logic                 out_dbz_ff;

   logic [FDM_W-1:0]     ua;
   logic [FDM_W-1:0]     ub;
   logic                 neg_low;
   logic [FDM_W-1:0]     q_fin;
   logic [FDM_W-1:0]     r_fin;

   assign adv        = !out_v_ff || rsp_tready;
   assign req_tready = adv || !s1_v_ff;

   // prepare: sign-extend, divisor magnitude, raw adjusted dividend
   always_comb begin
      ua = req_tuser ? req_tdata[FDM_W-1:0] : fdm_sext32(req_tdata[FDM_W-1:0]);
      ub = req_tuser ? req_tdata[2*FDM_W-1:FDM_W]
                     : fdm_sext32(req_tdata[2*FDM_W-1:FDM_W]);
      s1_in.ub    = ub;
      s1_in.a_neg = ua[FDM_W-1];
      s1_in.b_neg = ub[FDM_W-1];
      s1_in.mode  = req_tuser;
      s1_in.zero  = (ub == '0);
      s1_in.bm    = ub[FDM_W-1] ? (~ub + 1'b1) : ub;
      if (!ua[FDM_W-1]) begin
         s1_in.draw = ua;
      end else if (!ub[FDM_W-1]) begin
         s1_in.draw = ub + ~ua;
      end else begin
         s1_in.draw = ua + ~ub + FDM_W'(2);
      end
   end

   // magnitude of the adjusted dividend and its sign
   always_comb begin
      neg_low = s1_ff.a_neg && s1_ff.b_neg &&
                (s1_ff.draw > {1'b1, {(FDM_W-1){1'b0}}});
      div0_in.rem   = '0;
      div0_in.num   = neg_low ? (~s1_ff.draw + 1'b1) : s1_ff.draw;
      div0_in.bm    = s1_ff.bm;
      div0_in.ubm1  = s1_ff.ub - 1'b1;
      div0_in.a_neg = s1_ff.a_neg;
      div0_in.b_neg = s1_ff.b_neg;
      div0_in.d_neg = s1_ff.a_neg && (!s1_ff.b_neg || neg_low);
      div0_in.mode  = s1_ff.mode;
      div0_in.zero  = s1_ff.zero;
   end

   // apply signs to quotient and remainder
   always_comb begin
      pa_in.q     = (div_ff[FDM_STEPS].d_neg != div_ff[FDM_STEPS].b_neg) ?
                    (~div_ff[FDM_STEPS].num + 1'b1) : div_ff[FDM_STEPS].num;
      pa_in.r     = div_ff[FDM_STEPS].d_neg ?
                    (~div_ff[FDM_STEPS].rem + 1'b1) : div_ff[FDM_STEPS].rem;
      pa_in.ubm1  = div_ff[FDM_STEPS].ubm1;
      pa_in.a_neg = div_ff[FDM_STEPS].a_neg;
      pa_in.mode  = div_ff[FDM_STEPS].mode;
      pa_in.zero  = div_ff[FDM_STEPS].zero;
   end

   // remainder offset for a negative dividend, width wrap, zero-divisor result
   always_comb begin
      q_fin = pa_ff.q;
      r_fin = pa_ff.a_neg ? (pa_ff.ubm1 + pa_ff.r) : pa_ff.r;
      if (!pa_ff.mode) begin
         q_fin = fdm_sext32(q_fin);
         r_fin = fdm_sext32(r_fin);
      end
      if (pa_ff.zero) begin
         out_data_in = '0;
      end else begin
         out_data_in = {r_fin, q_fin};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff     <= 1'b0;
         div_v_ff[0] <= 1'b0;
         pa_v_ff     <= 1'b0;
         out_v_ff    <= 1'b0;
      end else begin
         if (req_tready) begin
            s1_v_ff <= req_tvalid;
         end
         if (adv) begin
            div_v_ff[0] <= s1_v_ff;
            pa_v_ff     <= div_v_ff[FDM_STEPS];
            out_v_ff    <= pa_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         s1_ff <= s1_in;
      end
      if (adv) begin
         div_ff[0]   <= div0_in;
         pa_ff       <= pa_in;
         out_data_ff <= out_data_in;
         out_dbz_ff  <= pa_ff.zero;
      end
   end

   for (genvar k = 0; k < FDM_STEPS; k++) begin : g_div
      always_ff @(posedge clock) begin
         if (reset) begin
            div_v_ff[k+1] <= 1'b0;
         end else if (adv) begin
            div_v_ff[k+1] <= div_v_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            div_ff[k+1] <= fdm_step(div_ff[k]);
         end
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_dbz_ff;

endmodule

// ===== design/fdm_checker.sv =====
// Port-level checks for floored_divide_modulo.
// Holds the checker module and the bind that attaches it to the top level.
// Depends only on the top-level ports.
module fdm_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [127:0] req_tdata,
   input logic         req_tuser,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [127:0] rsp_tdata,
   input logic         rsp_tuser
);

   // no result directly after reset
   a_quiet_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result shown right after reset");

   // a zero-divisor result carries zero quotient and remainder
   a_dbz_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == '0))
      else $error("divide-by-zero result is not zero");

   // an empty output register never blocks requests
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request refused with empty output");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled result changed");

endmodule

bind floored_divide_modulo fdm_checker u_fdm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking bench for floored_divide_modulo: 32/64-bit floored quotient and modulo.
// Predicts each result in a scoreboard class and compares on the response stream.
// Depends on design/floored_divide_modulo.sv and design/fdm_pkg.sv.
module testbench;

   localparam int W          = fdm_pkg::FDM_W;
   localparam int HOLD_SPAN  = 300;
   localparam int DRAIN_SPAN = 80;

   localparam bit MODE_32 = 1'b0;
   localparam bit MODE_64 = 1'b1;

   localparam bit [W-1:0] MIN64 = 64'h8000_0000_0000_0000;
   localparam bit [W-1:0] MAX64 = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam bit [W-1:0] ONES  = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef struct packed {
      bit [W-1:0] quotient;
      bit [W-1:0] remainder;
      bit         divide_by_zero;
   } divmod_type;

   class divmod_scoreboard;
      divmod_type expected_q[$];
      int         failures;

      function new();
         failures = 0;
      endfunction

      static function bit [W-1:0] widen32(bit [W-1:0] x);
         return {{(W-32){x[31]}}, x[31:0]};
      endfunction

      static function divmod_type floor_divmod(bit mode, bit [W-1:0] a_in, bit [W-1:0] b_in);
         divmod_type res;
         bit [W-1:0] a, b, mag_b, mag_d, shifted, q_mag, r_mag, q_s, r_s;
         bit         a_neg, b_neg, d_neg;
         res = '0;
         a = (mode == MODE_64) ? a_in : widen32(a_in);
         b = (mode == MODE_64) ? b_in : widen32(b_in);
         if (b == '0) begin
            res.divide_by_zero = 1'b1;
            return res;
         end
         a_neg = a[W-1];
         b_neg = b[W-1];
         mag_b = b_neg ? -b : b;
         if (!a_neg) begin
            mag_d = a;
            d_neg = 1'b0;
         end else if (!b_neg) begin
            mag_d = (b - 64'd1) + (-a);
            d_neg = 1'b1;
         end else begin
            shifted = a - b + 64'd1;
            d_neg   = shifted > MIN64;
            mag_d   = d_neg ? -shifted : shifted;
         end
         q_mag = mag_d / mag_b;
         r_mag = mag_d % mag_b;
         q_s   = (d_neg != b_neg) ? -q_mag : q_mag;
         r_s   = d_neg ? -r_mag : r_mag;
         res.quotient  = q_s;
         res.remainder = a_neg ? (b - 64'd1) + r_s : r_s;
         if (mode == MODE_32) begin
            res.quotient  = widen32(res.quotient);
            res.remainder = widen32(res.remainder);
         end
         return res;
      endfunction

      function void note_request(bit mode, bit [W-1:0] a, bit [W-1:0] b);
         expected_q.push_back(floor_divmod(mode, a, b));
      endfunction

      function void check_response(bit [W-1:0] q, bit [W-1:0] r, bit dbz);
         divmod_type exp_res;
         if (expected_q.size() == 0) begin
            $error("unexpected response: quotient %h remainder %h divide_by_zero %b", q, r, dbz);
            failures++;
            return;
         end
         exp_res = expected_q.pop_front();
         if (q !== exp_res.quotient) begin
            $error("quotient: expected %h, got %h", exp_res.quotient, q);
            failures++;
         end
         if (r !== exp_res.remainder) begin
            $error("remainder: expected %h, got %h", exp_res.remainder, r);
            failures++;
         end
         if (dbz !== exp_res.divide_by_zero) begin
            $error("divide_by_zero: expected %b, got %b", exp_res.divide_by_zero, dbz);
            failures++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [127:0] req_tdata;   // dividend [63:0], divisor [127:64]
   logic         req_tuser;   // mode [0]
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [127:0] rsp_tdata;   // quotient [63:0], remainder [127:64]
   logic         rsp_tuser;   // divide_by_zero [0]

   bit tx_idle_on   = 1'b1;
   bit rx_idle_on   = 1'b1;
   bit hold_request = 1'b0;

   divmod_scoreboard board = new();

   floored_divide_modulo uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (reset === 1'b0) begin
         if (req_tvalid && req_tready)
            board.note_request(req_tuser, req_tdata[63:0], req_tdata[127:64]);
         if (rsp_tvalid && rsp_tready)
            board.check_response(rsp_tdata[63:0], rsp_tdata[127:64], rsp_tuser);
      end
   end

   function automatic bit [W-1:0] pick_operand();
      bit [W-1:0] v;
      int         s;
      case ($urandom_range(0, 5))
         0: v = {$urandom, $urandom};
         1: begin
            s = int'($urandom_range(0, 40)) - 20;
            v = W'(s);
         end
         2: begin
            case ($urandom_range(0, 5))
               0: v = '0;
               1: v = 64'd1;
               2: v = ONES;
               3: v = MIN64;
               4: v = MAX64;
               default: v = MIN64 + 64'd1;
            endcase
         end
         3: begin
            v = {$urandom, $urandom} >> $urandom_range(0, W-1);
            if ($urandom_range(0, 1)) v = -v;
         end
         default: begin
            v[63:32] = $urandom;
            case ($urandom_range(0, 5))
               0: v[31:0] = 32'h0;
               1: v[31:0] = 32'h1;
               2: v[31:0] = 32'hFFFF_FFFF;
               3: v[31:0] = 32'h8000_0000;
               4: v[31:0] = 32'h7FFF_FFFF;
               default: v[31:0] = $urandom;
            endcase
         end
      endcase
      return v;
   endfunction

   task automatic send(bit mode, bit [W-1:0] a, bit [W-1:0] b);
      req_tvalid <= 1'b1;
      req_tdata  <= {b, a};
      req_tuser  <= mode;
      do @(posedge clock); while (!req_tready);
      if (tx_idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   task automatic send_random(int count);
      for (int i = 0; i < count; i++)
         send(1'($urandom_range(0, 1)), pick_operand(), pick_operand());
   endtask

   initial begin
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_SPAN) @(posedge clock);
            hold_request = 1'b0;
         end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   initial begin
      #(20ns * 200000);
      $display("testbench: errors");
      $finish;
   end

   initial begin
      int guard;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= MODE_64;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send(MODE_64, 64'd0, 64'd1);
      send(MODE_64, MAX64, 64'd1);
      send(MODE_64, MIN64, 64'd1);
      send(MODE_64, MIN64, ONES);
      send(MODE_64, MIN64, MIN64);
      send(MODE_64, ONES, MIN64);
      send(MODE_64, MAX64, MIN64);
      send(MODE_64, MAX64, MAX64);
      send(MODE_64, -64'd7, 64'd2);
      send(MODE_64, 64'd7, -64'd2);
      send(MODE_64, -64'd7, -64'd2);
      send(MODE_64, ONES, 64'd1);
      send(MODE_64, 64'd12345, 64'd0);
      send(MODE_64, MIN64, 64'd0);
      send(MODE_32, 64'hDEAD_BEEF_0000_0007, 64'h1234_5678_FFFF_FFFE);
      send(MODE_32, 64'h0000_0000_8000_0000, ONES);
      send(MODE_32, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_8000_0000);
      send(MODE_32, 64'h0000_0000_8000_0000, 64'hFFFF_FFFF_8000_0000);
      send(MODE_32, 64'h0000_0000_7FFF_FFFF, 64'h0000_0000_0000_0001);
      send(MODE_32, 64'h5555_5555_0000_0011, 64'hAAAA_AAAA_0000_0000);
      send(MODE_32, 64'hFFFF_FFFF_FFFF_FFF9, 64'h0000_0000_0000_0003);
      send(MODE_32, 64'h0000_0000_7FFF_FFFF, 64'h0000_0000_8000_0000);

      tx_idle_on   = 1'b0;
      hold_request = 1'b1;
      send_random(150);
      tx_idle_on = 1'b1;
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);

      send_random(250);
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      send_random(80);
      req_tvalid <= 1'b0;

      guard = 0;
      while (board.pending() != 0 && guard < 5000) begin
         @(posedge clock);
         guard++;
      end
      repeat (DRAIN_SPAN) @(posedge clock);
      if (board.failures == 0 && board.pending() == 0) begin
         $display("testbench: clean");
      end else begin
         if (board.pending() != 0)
            $error("%0d expected responses never arrived", board.pending());
         $display("testbench: errors");
      end
      $finish;
   end

endmodule
